[sv/hex_grid_pixel_to_axial_top_assert.svh]
// Assertion macros for the pixel to axial hex converter.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef HEX_GRID_PIXEL_TO_AXIAL_TOP_ASSERT_SVH
`define HEX_GRID_PIXEL_TO_AXIAL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HGPA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HGPA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hgpa_pkg.sv]
// Shared widths, register indexes and reset values for the pixel to axial converter.
// Depends on nothing; used by hex_grid_pixel_to_axial_top.
`timescale 1ns / 1ps

package hgpa_pkg;

  localparam int unsigned PtW       = 24;
  localparam int unsigned InvW      = 24;
  localparam int unsigned InvFrac   = 16;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned CoefFrac  = 14;
  localparam int unsigned OutW      = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned NumStages = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginX  = 3'd0,
    CfgOriginY  = 3'd1,
    CfgInvSizeX = 3'd2,
    CfgInvSizeY = 3'd3,
    CfgCoefQx   = 3'd4,
    CfgCoefQy   = 3'd5,
    CfgCoefRx   = 3'd6,
    CfgCoefRy   = 3'd7
  } cfg_reg_e;

  localparam logic signed [PtW-1:0]   RstOrigin  = '0;
  localparam logic        [InvW-1:0]  RstInvSize = 24'd65536;
  localparam logic signed [CoefW-1:0] RstCoefQx  = 16'sd9459;
  localparam logic signed [CoefW-1:0] RstCoefQy  = -16'sd5461;
  localparam logic signed [CoefW-1:0] RstCoefRx  = 16'sd0;
  localparam logic signed [CoefW-1:0] RstCoefRy  = 16'sd10923;

endpackage

[sv/hex_grid_pixel_to_axial_top.sv]
// Pixel point to axial hex cell converter with cube rounding, six register stages.
// Depends on hgpa_pkg and hex_grid_pixel_to_axial_top_assert.svh.
//
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_stall_o   point_x_i, point_y_i
// out      out        out_valid_o/out_stall_i hex_q_o, hex_r_o
//
// One item enters per clock while in_stall_o is low, and results leave in the order items entered.
// The stages are offset, scale multiply, matrix multiply,
// sum, rounding, and cube fix-up with saturation.
// Each stage holds only while it is full and the stage after it holds, so bubbles close up.
// Reset clears the valid bits and loads the default layout registers.
`timescale 1ns / 1ps
`include "hex_grid_pixel_to_axial_top_assert.svh"

module hex_grid_pixel_to_axial_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [hgpa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic        [hgpa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [hgpa_pkg::PtW-1:0]     point_x_i,
  input  logic signed [hgpa_pkg::PtW-1:0]     point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [hgpa_pkg::OutW-1:0]    hex_q_o,
  output logic signed [hgpa_pkg::OutW-1:0]    hex_r_o
);

  localparam int unsigned NumSt   = hgpa_pkg::NumStages;
  localparam int unsigned TotFrac = FRAC_BITS + hgpa_pkg::CoefFrac;
  localparam int unsigned DW      = hgpa_pkg::PtW + 1;
  localparam int unsigned ProdW   = 2 * DW;
  localparam int unsigned PW      = ProdW - hgpa_pkg::InvFrac;
  localparam int unsigned MulW    = hgpa_pkg::CoefW + PW;
  localparam int unsigned VW      = MulW + 3;
  localparam int unsigned RndW    = VW + 1 - TotFrac;
  localparam int unsigned ErrW    = TotFrac;
  localparam int unsigned SelW    = RndW + 2;

  localparam logic signed [VW:0]     Half  = (VW+1)'(1) <<< (TotFrac - 1);
  localparam logic signed [SelW-1:0] SatHi = SelW'(2 ** (hgpa_pkg::OutW - 1) - 1);
  localparam logic signed [SelW-1:0] SatLo = SelW'(-(2 ** (hgpa_pkg::OutW - 1)));

  function automatic logic signed [RndW-1:0] round_away(input logic signed [VW-1:0] v);
    logic [VW:0] t;
    t = (VW+1)'(v) + Half - (VW+1)'(v[VW-1]);
    return t[VW:TotFrac];
  endfunction

  function automatic logic [ErrW-1:0] round_err(input logic signed [VW-1:0] v);
    logic [ErrW-1:0] f;
    f = v[ErrW-1:0];
    return f[ErrW-1] ? (~f + ErrW'(1)) : f;
  endfunction

  function automatic logic signed [hgpa_pkg::OutW-1:0] sat16(input logic signed [SelW-1:0] v);
    logic signed [SelW-1:0] c;
    c = v;
    if (v > SatHi) begin
      c = SatHi;
    end else if (v < SatLo) begin
      c = SatLo;
    end
    return c[hgpa_pkg::OutW-1:0];
  endfunction

  logic signed [hgpa_pkg::PtW-1:0]   origin_x_q, origin_y_q;
  logic        [hgpa_pkg::InvW-1:0]  inv_size_x_q, inv_size_y_q;
  logic signed [hgpa_pkg::CoefW-1:0] coef_qx_q, coef_qy_q, coef_rx_q, coef_ry_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= hgpa_pkg::RstOrigin;
      origin_y_q   <= hgpa_pkg::RstOrigin;
      inv_size_x_q <= hgpa_pkg::RstInvSize;
      inv_size_y_q <= hgpa_pkg::RstInvSize;
      coef_qx_q    <= hgpa_pkg::RstCoefQx;
      coef_qy_q    <= hgpa_pkg::RstCoefQy;
      coef_rx_q    <= hgpa_pkg::RstCoefRx;
      coef_ry_q    <= hgpa_pkg::RstCoefRy;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (hgpa_pkg::cfg_reg_e'(cfg_index_i))
        hgpa_pkg::CfgOriginX:  origin_x_q   <= cfg_data_i;
        hgpa_pkg::CfgOriginY:  origin_y_q   <= cfg_data_i;
        hgpa_pkg::CfgInvSizeX: inv_size_x_q <= cfg_data_i;
        hgpa_pkg::CfgInvSizeY: inv_size_y_q <= cfg_data_i;
        hgpa_pkg::CfgCoefQx:   coef_qx_q    <= cfg_data_i[hgpa_pkg::CoefW-1:0];
        hgpa_pkg::CfgCoefQy:   coef_qy_q    <= cfg_data_i[hgpa_pkg::CoefW-1:0];
        hgpa_pkg::CfgCoefRx:   coef_rx_q    <= cfg_data_i[hgpa_pkg::CoefW-1:0];
        hgpa_pkg::CfgCoefRy:   coef_ry_q    <= cfg_data_i[hgpa_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads; the last stage, when the output is not stalled.
  logic [NumSt-1:0] vld_q, vld_d, stg_en;

  always_comb begin
    stg_en[NumSt-1] = !vld_q[NumSt-1] || !out_stall_i;
    for (int k = NumSt - 2; k >= 0; k--) begin
      stg_en[k] = !vld_q[k] || stg_en[k+1];
    end
    vld_d[0] = stg_en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumSt; k++) begin
      vld_d[k] = stg_en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !stg_en[0];
  assign out_valid_o = vld_q[NumSt-1];

  logic signed [DW-1:0]    d_x_d, d_y_d, d_x_q, d_y_q;
  logic signed [ProdW-1:0] prod_x, prod_y;
  logic signed [PW-1:0]    p_x_d, p_y_d, p_x_q, p_y_q;
  logic signed [MulW-1:0]  m_qx_d, m_qy_d, m_rx_d, m_ry_d;
  logic signed [MulW-1:0]  m_qx_q, m_qy_q, m_rx_q, m_ry_q;
  logic signed [VW-1:0]    qf_d, rf_d, sf_d, qf_q, rf_q, sf_q;
  logic signed [RndW-1:0]  q_d, r_d, s_d, q_q, r_q, s_q;
  logic        [ErrW-1:0]  qe_d, re_d, se_d, qe_q, re_q, se_q;
  logic signed [SelW-1:0]  q_sel, r_sel;
  logic signed [SelW-1:0]  cube_sum;
  logic signed [hgpa_pkg::OutW-1:0] hex_q_d, hex_r_d, hex_q_q, hex_r_q;

  always_comb begin
    d_x_d  = DW'(point_x_i) - DW'(origin_x_q);
    d_y_d  = DW'(point_y_i) - DW'(origin_y_q);
    prod_x = d_x_q * $signed({1'b0, inv_size_x_q});
    prod_y = d_y_q * $signed({1'b0, inv_size_y_q});
    p_x_d  = prod_x[ProdW-1:hgpa_pkg::InvFrac];
    p_y_d  = prod_y[ProdW-1:hgpa_pkg::InvFrac];
    m_qx_d = coef_qx_q * p_x_q;
    m_qy_d = coef_qy_q * p_y_q;
    m_rx_d = coef_rx_q * p_x_q;
    m_ry_d = coef_ry_q * p_y_q;
    qf_d   = VW'(m_qx_q) + VW'(m_qy_q);
    rf_d   = VW'(m_rx_q) + VW'(m_ry_q);
    sf_d   = -(VW'(m_qx_q) + VW'(m_qy_q) + VW'(m_rx_q) + VW'(m_ry_q));
    q_d    = round_away(qf_q);
    r_d    = round_away(rf_q);
    s_d    = round_away(sf_q);
    qe_d   = round_err(qf_q);
    re_d   = round_err(rf_q);
    se_d   = round_err(sf_q);
  end

  always_comb begin
    q_sel = SelW'(q_q);
    r_sel = SelW'(r_q);
    if (qe_q > re_q && qe_q > se_q) begin
      q_sel = -SelW'(r_q) - SelW'(s_q);
    end else if (re_q > se_q) begin
      r_sel = -SelW'(q_q) - SelW'(s_q);
    end
    hex_q_d  = sat16(q_sel);
    hex_r_d  = sat16(r_sel);
    cube_sum = SelW'(q_q) + SelW'(r_q) + SelW'(s_q);
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[0]) begin
      d_x_q <= d_x_d;
      d_y_q <= d_y_d;
    end
    if (stg_en[1]) begin
      p_x_q <= p_x_d;
      p_y_q <= p_y_d;
    end
    if (stg_en[2]) begin
      m_qx_q <= m_qx_d;
      m_qy_q <= m_qy_d;
      m_rx_q <= m_rx_d;
      m_ry_q <= m_ry_d;
    end
    if (stg_en[3]) begin
      qf_q <= qf_d;
      rf_q <= rf_d;
      sf_q <= sf_d;
    end
    if (stg_en[4]) begin
      q_q  <= q_d;
      r_q  <= r_d;
      s_q  <= s_d;
      qe_q <= qe_d;
      re_q <= re_d;
      se_q <= se_d;
    end
    if (stg_en[5]) begin
      hex_q_q <= hex_q_d;
      hex_r_q <= hex_r_d;
    end
  end

  assign hex_q_o = hex_q_q;
  assign hex_r_o = hex_r_q;

  `HGPA_ASSERT_IMP(a_stall_only_full, in_stall_o, &vld_q, "input stalled with an empty stage")
  `HGPA_ASSERT_IMP(a_cube_sum, vld_q[NumSt-2], (cube_sum == 0 || cube_sum == 1 || cube_sum == -1), "rounded cube coordinates drift by more than one")
  `HGPA_ASSERT_NXT(a_out_load, vld_q[NumSt-2] && stg_en[NumSt-1], out_valid_o, "finished item did not reach the output")
  `HGPA_ASSERT_NXT(a_round_hold, out_valid_o && out_stall_i && vld_q[NumSt-2], vld_q[NumSt-2] && $stable(q_q) && $stable(qe_q), "rounding stage changed under a stalled output")

endmodule
